// ----- rtl/hmscan_pkg.sv -----
// ----------------------------------------------------------------------------
// hmscan_pkg
// Shared constants and types for the monochrome hi-res scanout unit.
// ----------------------------------------------------------------------------
package hmscan_pkg;

    localparam int SCREEN_ROWS  = 192;
    localparam int SCREEN_COLS  = 40;
    localparam int PIX_PER_BYTE = 7;

    localparam int SHADOW_DEPTH = SCREEN_ROWS * SCREEN_COLS;
    localparam int SH_AW        = $clog2(SHADOW_DEPTH);
    localparam int BLK_ROWS     = (SCREEN_ROWS + 7) / 8;
    localparam int BLK_AW       = (BLK_ROWS > 1) ? $clog2(BLK_ROWS) : 1;
    localparam int COL_IW       = (SCREEN_COLS > 1) ? $clog2(SCREEN_COLS) : 1;

    localparam int ROW_W   = 8;
    localparam int COL_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int COLOR_W = 32;
    localparam int PIDX_W  = 16;
    localparam int ADDR_W  = 15;
    localparam int BIT_W   = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_TEXT_MODE  = 3'd0;
    localparam t_cfg_idx CFG_MIXED_MODE = 3'd1;
    localparam t_cfg_idx CFG_PAGE_TWO   = 3'd2;
    localparam t_cfg_idx CFG_MONO_COLOR = 3'd3;

    localparam logic REQ_FRAME_START = 1'b0;
    localparam logic REQ_SCREEN_BYTE = 1'b1;

    localparam logic [COLOR_W-1:0] MONO_COLOR_RESET = 32'hFF2B_D84A;
    localparam logic [COLOR_W-1:0] PIXEL_DARK       = 32'h0000_0000;
    localparam logic [ADDR_W-1:0]  BASE_PAGE1       = 15'h2000;
    localparam logic [ADDR_W-1:0]  BASE_PAGE2       = 15'h4000;
    localparam logic [ADDR_W-1:0]  STEP_THIRD       = 15'h0028;
    localparam logic [ADDR_W-1:0]  STEP_GROUP       = 15'h0080;
    localparam logic [ADDR_W-1:0]  STEP_LINE        = 15'h0400;
    localparam logic [ROW_W-1:0]   MIXED_LIMIT      = 8'd160;
    localparam logic [BIT_W-1:0]   LAST_BIT         = 3'(PIX_PER_BYTE - 1);

endpackage

// ----- rtl/hires_mono_scanout_with_change_tracking_unit.sv -----
// ----------------------------------------------------------------------------
// hires_mono_scanout_with_change_tracking_unit
// Hi-res monochrome scanout with a shadow copy of screen memory and sticky
// per-block change flags.
//
//   channel   | handshake                  | contents
//   ----------+----------------------------+---------------------------------
//   config    | i_cfg_we                   | i_cfg_index, i_cfg_data
//   input     | i_in_valid / o_in_ready    | req type, row, column, byte
//   output    | o_out_valid / i_out_ready  | pixel color, index, address, flags
//
// A rendered screen byte gives seven pixel transactions, one per cycle while
// the output is ready, so the pixel serializer sets the pace of a steady
// stream of bytes. A frame start or a dropped byte goes no further than the
// update stage. After reset the shadow memory is cleared, during which no
// input transaction is taken. Output stalls hold the serializer and its
// one-entry buffer; input is taken again as soon as that buffer drains.
// ----------------------------------------------------------------------------
module hires_mono_scanout_with_change_tracking_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  hmscan_pkg::t_cfg_idx                i_cfg_index,
    input  logic [hmscan_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_req_type,
    input  logic [hmscan_pkg::ROW_W-1:0]        i_row,
    input  logic [hmscan_pkg::COL_W-1:0]        i_col,
    input  logic [hmscan_pkg::BYTE_W-1:0]       i_screen_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [hmscan_pkg::COLOR_W-1:0]      o_pixel_color,
    output logic [hmscan_pkg::PIDX_W-1:0]       o_pixel_index,
    output logic [hmscan_pkg::ADDR_W-1:0]       o_source_address,
    output logic                                o_block_changed,
    output logic                                o_last_pixel
);
    import hmscan_pkg::*;

    // Configuration registers.
    logic               r_text_mode;
    logic               r_mixed_mode;
    logic               r_page_two;
    logic [COLOR_W-1:0] r_mono_color;

    // Memories.
    logic [BYTE_W-1:0]      shadow_mem [SHADOW_DEPTH];
    logic [SCREEN_COLS-1:0] flag_mem   [BLK_ROWS];
    logic                   r_rowv     [BLK_ROWS];

    logic [BYTE_W-1:0]      r_sh_rd;
    logic [SCREEN_COLS-1:0] r_fl_rd;

    // Clearing pass.
    logic             r_clr;
    logic [SH_AW-1:0] r_clr_cnt;

    // Update stage.
    logic              r_a_vld;
    logic              r_a_req;
    logic [ROW_W-1:0]  r_a_row;
    logic [COL_W-1:0]  r_a_col;
    logic [BYTE_W-1:0] r_a_byte;
    logic [SH_AW-1:0]  r_a_saddr;

    // Forwarding of the last write.
    logic                   r_fw_vld;
    logic [SH_AW-1:0]       r_fw_saddr;
    logic [BYTE_W-1:0]      r_fw_sdata;
    logic [BLK_AW-1:0]      r_fw_frow;
    logic [SCREEN_COLS-1:0] r_fw_fword;

    // Buffer stage.
    logic                    r_b_vld;
    logic [PIX_PER_BYTE-1:0] r_b_pix;
    logic                    r_b_flag;
    logic [ADDR_W-1:0]       r_b_addr;
    logic [PIDX_W-1:0]       r_b_pidx;

    // Pixel serializer.
    logic                    r_c_vld;
    logic [BIT_W-1:0]        r_c_bit;
    logic [PIX_PER_BYTE-1:0] r_c_pix;
    logic                    r_c_flag;
    logic [ADDR_W-1:0]       r_c_addr;
    logic [PIDX_W-1:0]       r_c_pidx;

    logic                   n_b_vld;
    logic                   n_c_vld;

    logic                   in_fire;
    logic                   out_fire;
    logic                   c_last;
    logic                   c_take;
    logic                   a_render;
    logic                   a_frame;
    logic [BLK_AW-1:0]      a_frow;
    logic [COL_IW-1:0]      a_cidx;
    logic [BYTE_W-1:0]      sh_old;
    logic [SCREEN_COLS-1:0] fl_old;
    logic [SCREEN_COLS-1:0] fl_new;
    logic                   a_chg;
    logic                   a_flag;
    logic [ADDR_W-1:0]      a_addr;
    logic [PIDX_W-1:0]      a_pidx;
    logic [SH_AW-1:0]       in_saddr;
    logic [BLK_AW-1:0]      in_frow;
    logic                   sh_we;
    logic [SH_AW-1:0]       sh_waddr;
    logic [BYTE_W-1:0]      sh_wdata;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_mode  <= 1'b0;
            r_mixed_mode <= 1'b0;
            r_page_two   <= 1'b0;
            r_mono_color <= MONO_COLOR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TEXT_MODE:  r_text_mode  <= i_cfg_data[0];
                CFG_MIXED_MODE: r_mixed_mode <= i_cfg_data[0];
                CFG_PAGE_TWO:   r_page_two   <= i_cfg_data[0];
                CFG_MONO_COLOR: r_mono_color <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // Update stage logic.
    always_comb begin
        a_frame  = r_a_vld && (r_a_req == REQ_FRAME_START);
        a_render = r_a_vld && (r_a_req == REQ_SCREEN_BYTE) && !r_text_mode
                   && (32'(r_a_row) < SCREEN_ROWS) && (32'(r_a_col) < SCREEN_COLS)
                   && !(r_mixed_mode && (r_a_row >= MIXED_LIMIT));
        a_frow   = BLK_AW'(r_a_row >> 3);
        a_cidx   = COL_IW'(r_a_col);
        sh_old   = (r_fw_vld && (r_fw_saddr == r_a_saddr)) ? r_fw_sdata : r_sh_rd;
        if (r_rowv[a_frow]) begin
            fl_old = (r_fw_vld && (r_fw_frow == a_frow)) ? r_fw_fword : r_fl_rd;
        end else begin
            fl_old = '0;
        end
        a_chg  = (sh_old != r_a_byte);
        fl_new = fl_old | (SCREEN_COLS'(a_chg) << a_cidx);
        a_flag = fl_new[a_cidx];
        a_addr = (r_page_two ? BASE_PAGE2 : BASE_PAGE1)
                 + ADDR_W'(r_a_row[7:6]) * STEP_THIRD
                 + ADDR_W'(r_a_row[5:3]) * STEP_GROUP
                 + ADDR_W'(r_a_row[2:0]) * STEP_LINE
                 + ADDR_W'(r_a_col);
        a_pidx = PIDX_W'(32'(r_a_row) * (SCREEN_COLS * PIX_PER_BYTE)
                         + 32'(r_a_col) * PIX_PER_BYTE);
    end

    // Handshake and stage control.
    always_comb begin
        out_fire   = r_c_vld && i_out_ready;
        c_last     = (r_c_bit == LAST_BIT);
        c_take     = r_b_vld && (!r_c_vld || (out_fire && c_last));
        o_in_ready = !r_clr && !a_render && (!r_b_vld || c_take);
        in_fire    = i_in_valid && o_in_ready;
        in_saddr   = SH_AW'(32'(i_row) * SCREEN_COLS + 32'(i_col));
        in_frow    = BLK_AW'(i_row >> 3);
        n_b_vld    = a_render || (r_b_vld && !c_take);
        if (c_take) begin
            n_c_vld = 1'b1;
        end else if (out_fire && c_last) begin
            n_c_vld = 1'b0;
        end else begin
            n_c_vld = r_c_vld;
        end
        sh_we    = r_clr || a_render;
        sh_waddr = r_clr ? r_clr_cnt : r_a_saddr;
        sh_wdata = r_clr ? '0 : r_a_byte;
    end

    // Shadow memory.
    always_ff @(posedge i_clk) begin
        if (sh_we) begin
            shadow_mem[sh_waddr] <= sh_wdata;
        end
        if (in_fire) begin
            r_sh_rd <= shadow_mem[in_saddr];
        end
    end

    // Block flag memory, one row of flags per entry.
    always_ff @(posedge i_clk) begin
        if (a_render) begin
            flag_mem[a_frow] <= fl_new;
        end
        if (in_fire) begin
            r_fl_rd <= flag_mem[in_frow];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_cnt <= '0;
            r_a_vld   <= 1'b0;
            r_fw_vld  <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_c_bit   <= '0;
            for (int i = 0; i < BLK_ROWS; i++) begin
                r_rowv[i] <= 1'b0;
            end
        end else begin
            if (r_clr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == SH_AW'(SHADOW_DEPTH - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            r_a_vld  <= in_fire;
            r_fw_vld <= a_render;
            r_b_vld  <= n_b_vld;
            r_c_vld  <= n_c_vld;
            if (c_take) begin
                r_c_bit <= '0;
            end else if (out_fire) begin
                r_c_bit <= r_c_bit + 1'b1;
            end
            if (a_frame) begin
                for (int i = 0; i < BLK_ROWS; i++) begin
                    r_rowv[i] <= 1'b0;
                end
            end else if (a_render) begin
                r_rowv[a_frow] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_req   <= i_req_type;
            r_a_row   <= i_row;
            r_a_col   <= i_col;
            r_a_byte  <= i_screen_byte;
            r_a_saddr <= in_saddr;
        end
        if (a_render) begin
            r_fw_saddr <= r_a_saddr;
            r_fw_sdata <= r_a_byte;
            r_fw_frow  <= a_frow;
            r_fw_fword <= fl_new;
            r_b_pix    <= r_a_byte[PIX_PER_BYTE-1:0];
            r_b_flag   <= a_flag;
            r_b_addr   <= a_addr;
            r_b_pidx   <= a_pidx;
        end
        if (c_take) begin
            r_c_pix  <= r_b_pix;
            r_c_flag <= r_b_flag;
            r_c_addr <= r_b_addr;
            r_c_pidx <= r_b_pidx;
        end else if (out_fire) begin
            r_c_pidx <= r_c_pidx + 1'b1;
        end
    end

    assign o_out_valid      = r_c_vld;
    assign o_pixel_color    = r_c_pix[r_c_bit] ? r_mono_color : PIXEL_DARK;
    assign o_pixel_index    = r_c_pidx;
    assign o_source_address = r_c_addr;
    assign o_block_changed  = r_c_flag;
    assign o_last_pixel     = c_last;

endmodule
